// ----- rtl/core/morse_character_keyer_assert.svh -----
// assertion macros used by the keyer top level
`ifndef MORSE_CHARACTER_KEYER_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MCK_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MCK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mck_pkg.sv -----
// shared types, constants and letter table of the morse keyer
package mck_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_Z     = 8'h7A;

   localparam logic [2:0] DOT_UNITS   = 3'd1;
   localparam logic [2:0] DASH_UNITS  = 3'd3;
   localparam logic [2:0] ELEM_GAP    = 3'd1;
   localparam logic [2:0] LETTER_GAP  = 3'd3;
   localparam logic [2:0] SPACE_UNITS = 3'd5;
   localparam logic [2:0] BAD_UNITS   = 3'd0;

   localparam logic LEVEL_KEYED = 1'b0;
   localparam logic LEVEL_IDLE  = 1'b1;

   localparam int MAX_ELEMS = 4;

   typedef enum logic [1:0] {
      KIND_LETTER,
      KIND_SPACE,
      KIND_BAD
   } char_kind_type;

   // element count and pattern, bit 0 is the first element, 1 means dash
   typedef struct packed {
      logic [2:0]           count;
      logic [MAX_ELEMS-1:0] pattern;
   } letter_code_type;

   // classified character handed from front to back
   typedef struct packed {
      char_kind_type        kind;
      logic [2:0]           count;
      logic [MAX_ELEMS-1:0] pattern;
   } char_desc_type;

   // morse table for 'a' to 'z'
   function automatic letter_code_type letter_code(input logic [4:0] idx);
      letter_code_type lc;
      unique case (idx)
         5'd0:    lc = '{count: 3'd2, pattern: 4'b0010}; // a .-
         5'd1:    lc = '{count: 3'd4, pattern: 4'b0001}; // b -...
         5'd2:    lc = '{count: 3'd4, pattern: 4'b0101}; // c -.-.
         5'd3:    lc = '{count: 3'd3, pattern: 4'b0001}; // d -..
         5'd4:    lc = '{count: 3'd1, pattern: 4'b0000}; // e .
         5'd5:    lc = '{count: 3'd4, pattern: 4'b0100}; // f ..-.
         5'd6:    lc = '{count: 3'd3, pattern: 4'b0011}; // g --.
         5'd7:    lc = '{count: 3'd4, pattern: 4'b0000}; // h ....
         5'd8:    lc = '{count: 3'd2, pattern: 4'b0000}; // i ..
         5'd9:    lc = '{count: 3'd4, pattern: 4'b1110}; // j .---
         5'd10:   lc = '{count: 3'd3, pattern: 4'b0101}; // k -.-
         5'd11:   lc = '{count: 3'd4, pattern: 4'b0010}; // l .-..
         5'd12:   lc = '{count: 3'd2, pattern: 4'b0011}; // m --
         5'd13:   lc = '{count: 3'd2, pattern: 4'b0001}; // n -.
         5'd14:   lc = '{count: 3'd3, pattern: 4'b0111}; // o ---
         5'd15:   lc = '{count: 3'd4, pattern: 4'b0110}; // p .--.
         5'd16:   lc = '{count: 3'd4, pattern: 4'b1011}; // q --.-
         5'd17:   lc = '{count: 3'd3, pattern: 4'b0010}; // r .-.
         5'd18:   lc = '{count: 3'd3, pattern: 4'b0000}; // s ...
         5'd19:   lc = '{count: 3'd1, pattern: 4'b0001}; // t -
         5'd20:   lc = '{count: 3'd3, pattern: 4'b0100}; // u ..-
         5'd21:   lc = '{count: 3'd4, pattern: 4'b1000}; // v ...-
         5'd22:   lc = '{count: 3'd3, pattern: 4'b0110}; // w .--
         5'd23:   lc = '{count: 3'd4, pattern: 4'b1001}; // x -..-
         5'd24:   lc = '{count: 3'd4, pattern: 4'b1101}; // y -.--
         5'd25:   lc = '{count: 3'd4, pattern: 4'b0011}; // z --..
         default: lc = '{count: 3'd1, pattern: 4'b0000};
      endcase
      return lc;
   endfunction

endpackage

// ----- rtl/core/morse_character_keyer.sv -----
// top level of the morse character keyer
// Usage:
//  - req channel: one ascii code per transaction on req_char_code. Lowercase
//    'a' to 'z' and space are keyed; anything else gives a single flagged
//    segment (idle level, zero units, rsp_bad_char set).
//  - rsp channel: one line segment per transaction (level, length in dot
//    units, bad flag, last flag). A letter of k elements gives 2*k segments,
//    mark then gap for each element; space gives one idle segment of 5 units.
//  - path: with the queue empty, the first segment of a character is valid
//    after the front register, a queue entry and the back output register.
//  - throughput: one segment per cycle from the back sequencer while rsp_ready
//    is high; a character gives 1 to 8 segments, and the front accepts while
//    the back works, until the front register and QUEUE_DEPTH entries fill.
//  - reset clears all valid flags, queue pointers and the element walk.
//  - when rsp_ready is low the output segment holds; the back stalls, then
//    the queue fills and req_ready drops.
module morse_character_keyer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_level,
   output logic [2:0] rsp_unit_count,
   output logic       rsp_bad_char,
   output logic       rsp_last_segment
);
   import mck_pkg::*;

   logic          front_valid;
   logic          q_push_ready;
   char_desc_type front_desc;
   logic          q_head_valid;
   char_desc_type q_head;
   logic          q_pop;

   // accept and classify
   mck_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .desc_valid    (front_valid),
      .desc_ready    (q_push_ready),
      .desc          (front_desc)
   );

   // descriptor queue
   mck_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (q_push_ready),
      .push_data  (front_desc),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .head_data  (q_head)
   );

   // segment sequencer
   mck_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_head_valid),
      .head_data        (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_level   (rsp_line_level),
      .rsp_unit_count   (rsp_unit_count),
      .rsp_bad_char     (rsp_bad_char),
      .rsp_last_segment (rsp_last_segment)
   );

`include "morse_character_keyer_assert.svh"

   // checks
   `MCK_ASSERT_IMPLY(a_pop_has_head, q_pop, q_head_valid, "pop from empty queue")
   `MCK_ASSERT_NEXT(a_accept_fills_front, req_valid && req_ready, front_valid, "accepted transaction lost in front")
   `MCK_ASSERT_IMPLY(a_bad_is_single, rsp_valid && rsp_bad_char, rsp_last_segment && rsp_unit_count == BAD_UNITS && rsp_line_level == LEVEL_IDLE, "bad character segment malformed")
   `MCK_ASSERT_IMPLY(a_mark_shape, rsp_valid && rsp_line_level == LEVEL_KEYED, !rsp_last_segment && (rsp_unit_count == DOT_UNITS || rsp_unit_count == DASH_UNITS), "keyed segment malformed")

endmodule

// ----- rtl/core/mck_front.sv -----
// front stage: takes characters and classifies them into descriptors
module mck_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   output logic                  desc_valid,
   input  logic                  desc_ready,
   output mck_pkg::char_desc_type desc
);
   import mck_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   char_desc_type   desc_ff;
   char_desc_type   desc_in;
   letter_code_type lc;
   logic            take;

   // classify the incoming character
   always_comb begin
      lc      = letter_code(5'(req_char_code - CHAR_A));
      desc_in = '{kind: KIND_BAD, count: 3'd1, pattern: '0};
      if (req_char_code == CHAR_SPACE) begin
         desc_in.kind = KIND_SPACE;
      end else if (req_char_code >= CHAR_A && req_char_code <= CHAR_Z) begin
         desc_in.kind    = KIND_LETTER;
         desc_in.count   = lc.count;
         desc_in.pattern = lc.pattern;
      end
   end

   // one-entry stage, refills in the cycle it drains
   assign req_ready = !valid_ff || desc_ready;
   assign take      = req_valid && req_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         desc_ff <= desc_in;
      end
   end

   assign desc_valid = valid_ff;
   assign desc       = desc_ff;

endmodule

// ----- rtl/core/mck_queue.sv -----
// short descriptor queue between front and back
module mck_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  mck_pkg::char_desc_type push_data,
   output logic                   head_valid,
   input  logic                   pop,
   output mck_pkg::char_desc_type head_data
);
   import mck_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   char_desc_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/mck_back.sv -----
// back stage: walks a descriptor and emits one line segment per cycle while rsp_ready is high
module mck_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  mck_pkg::char_desc_type head_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_line_level,
   output logic [2:0]             rsp_unit_count,
   output logic                   rsp_bad_char,
   output logic                   rsp_last_segment
);
   import mck_pkg::*;

   localparam int IDX_W = $clog2(MAX_ELEMS);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             gap_ff, gap_in;
   logic             valid_ff, valid_in;
   logic             level_ff, level_in;
   logic [2:0]       units_ff, units_in;
   logic             bad_ff, bad_in;
   logic             last_ff, last_in;
   logic             load;
   logic             final_elem;

   assign load       = head_valid && (!valid_ff || rsp_ready);
   assign final_elem = (3'({1'b0, idx_ff}) + 3'd1) == head_data.count;

   // segment for the current element and phase
   always_comb begin
      level_in = LEVEL_IDLE;
      units_in = BAD_UNITS;
      bad_in   = 1'b0;
      last_in  = 1'b1;
      unique case (head_data.kind)
         KIND_SPACE: begin
            units_in = SPACE_UNITS;
         end
         KIND_LETTER: begin
            if (gap_ff) begin
               units_in = final_elem ? LETTER_GAP : ELEM_GAP;
               last_in  = final_elem;
            end else begin
               level_in = LEVEL_KEYED;
               units_in = head_data.pattern[idx_ff] ? DASH_UNITS : DOT_UNITS;
               last_in  = 1'b0;
            end
         end
         default: begin
            bad_in = 1'b1;
         end
      endcase
   end

   assign pop = load && last_in;

   // element walk: mark then gap, next element, restart after the last segment
   always_comb begin
      idx_in = idx_ff;
      gap_in = gap_ff;
      if (load) begin
         if (last_in) begin
            idx_in = '0;
            gap_in = 1'b0;
         end else if (gap_ff) begin
            idx_in = idx_ff + 1'b1;
            gap_in = 1'b0;
         end else begin
            gap_in = 1'b1;
         end
      end
   end

   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         gap_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         gap_ff   <= gap_in;
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= level_in;
         units_ff <= units_in;
         bad_ff   <= bad_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_line_level   = level_ff;
   assign rsp_unit_count   = units_ff;
   assign rsp_bad_char     = bad_ff;
   assign rsp_last_segment = last_ff;

endmodule

// ----- sim/tb_top.sv -----
// testbench for the morse character keyer: line segments checked against a scoreboard
`timescale 1ns / 1ps

module tb_top;
   import mck_pkg::*;

   // one line segment as seen on the rsp channel
   typedef struct packed {
      logic       line_level;
      logic [2:0] unit_count;
      logic       bad_char;
      logic       last_segment;
   } key_segment_type;

   localparam int MAX_WAIT     = 16;
   localparam int SETTLE_TIME  = 16;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code    = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic       rsp_line_level;
   logic [2:0] rsp_unit_count;
   logic       rsp_bad_char;
   logic       rsp_last_segment;

   key_segment_type pending_segments[$];
   int              mismatch_count = 0;
   int              send_idle_en   = 1;
   int              recv_idle_en   = 1;
   int              recv_wait      = 0;

   morse_character_keyer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_level   (rsp_line_level),
      .rsp_unit_count   (rsp_unit_count),
      .rsp_bad_char     (rsp_bad_char),
      .rsp_last_segment (rsp_last_segment)
   );

   always #1 clock = ~clock;

   // dots and dashes of each letter, first element first
   function automatic string letter_elements(input logic [4:0] idx);
      case (idx)
         5'd0:    return ".-";
         5'd1:    return "-...";
         5'd2:    return "-.-.";
         5'd3:    return "-..";
         5'd4:    return ".";
         5'd5:    return "..-.";
         5'd6:    return "--.";
         5'd7:    return "....";
         5'd8:    return "..";
         5'd9:    return ".---";
         5'd10:   return "-.-";
         5'd11:   return ".-..";
         5'd12:   return "--";
         5'd13:   return "-.";
         5'd14:   return "---";
         5'd15:   return ".--.";
         5'd16:   return "--.-";
         5'd17:   return ".-.";
         5'd18:   return "...";
         5'd19:   return "-";
         5'd20:   return "..-";
         5'd21:   return "...-";
         5'd22:   return ".--";
         5'd23:   return "-..-";
         5'd24:   return "-.--";
         default: return "--..";
      endcase
   endfunction

   // queue up the segments one character should produce
   task automatic expect_keying(input logic [7:0] code);
      string           elems;
      key_segment_type seg;
      logic            final_elem;
      if (code == CHAR_SPACE) begin
         seg = '{LEVEL_IDLE, SPACE_UNITS, 1'b0, 1'b1};
         pending_segments.push_back(seg);
      end else if (code < CHAR_A || code > CHAR_Z) begin
         seg = '{LEVEL_IDLE, BAD_UNITS, 1'b1, 1'b1};
         pending_segments.push_back(seg);
      end else begin
         elems = letter_elements(5'(code - CHAR_A));
         for (int i = 0; i < elems.len(); i++) begin
            final_elem = (i == elems.len() - 1);
            // mark, then the gap that follows it
            seg = '{LEVEL_KEYED, (elems[i] == "-") ? DASH_UNITS : DOT_UNITS, 1'b0, 1'b0};
            pending_segments.push_back(seg);
            seg = '{LEVEL_IDLE, final_elem ? LETTER_GAP : ELEM_GAP, 1'b0, final_elem};
            pending_segments.push_back(seg);
         end
      end
   endtask

   // mostly lowercase text, some spaces, the rest any byte
   function automatic logic [7:0] random_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return CHAR_A + 8'($urandom_range(0, 25));
      else if (pick < 80)
         return CHAR_SPACE;
      else
         return 8'($urandom_range(0, 255));
   endfunction

   // send one character transaction, optionally after an idle gap
   task automatic send_char(input logic [7:0] code);
      int gap;
      gap = send_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expect_keying(code);
   endtask

   // hold off the sender until every expected segment is back
   task automatic drain_segments();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   // compare one accepted segment with the oldest expectation
   task automatic check_segment();
      key_segment_type want;
      if (pending_segments.size() == 0) begin
         $error("segment with nothing expected: level %0d units %0d bad %0d last %0d",
                rsp_line_level, rsp_unit_count, rsp_bad_char, rsp_last_segment);
         mismatch_count++;
      end else begin
         want = pending_segments.pop_front();
         if (rsp_line_level !== want.line_level) begin
            $error("line_level: expected %0d, got %0d", want.line_level, rsp_line_level);
            mismatch_count++;
         end
         if (rsp_unit_count !== want.unit_count) begin
            $error("unit_count: expected %0d, got %0d", want.unit_count, rsp_unit_count);
            mismatch_count++;
         end
         if (rsp_bad_char !== want.bad_char) begin
            $error("bad_char: expected %0d, got %0d", want.bad_char, rsp_bad_char);
            mismatch_count++;
         end
         if (rsp_last_segment !== want.last_segment) begin
            $error("last_segment: expected %0d, got %0d", want.last_segment,
                   rsp_last_segment);
            mismatch_count++;
         end
      end
   endtask

   // receiver: check each segment, then stall a random number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_segment();
            recv_wait = recv_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // code boundaries, space, rejected codes and the shortest and longest letters
   task automatic test_boundary_codes();
      send_idle_en = 1;
      recv_idle_en = 1;
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h1F);
      send_char(CHAR_SPACE);
      send_char(8'h21);
      send_char(8'h60);
      send_char(CHAR_A);
      send_char(CHAR_Z);
      send_char(8'h7B);
      send_char(8'h7F);
      send_char(8'h80);
      send_char("A");
      send_char("0");
      send_char("e");
      send_char("t");
      send_char("h");
      send_char("j");
      send_char("q");
   endtask

   // random text with idling on both sides
   task automatic test_random_text(input int count);
      send_idle_en = 1;
      recv_idle_en = 1;
      repeat (count) send_char(random_char());
   endtask

   // full rate on both sides
   task automatic test_back_to_back(input int count);
      send_idle_en = 0;
      recv_idle_en = 0;
      repeat (count) send_char(random_char());
   endtask

   // sender at full rate into a stalling receiver, so the queue fills up
   task automatic test_receiver_backpressure(input int count);
      send_idle_en = 0;
      recv_idle_en = 1;
      repeat (count) send_char(random_char());
   endtask

   // short bursts, each drained completely before the next
   task automatic test_burst_drain(input int bursts, input int burst_len);
      send_idle_en = 1;
      recv_idle_en = 1;
      repeat (bursts) begin
         repeat (burst_len) send_char(random_char());
         drain_segments();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boundary_codes();
      test_random_text(104);
      test_back_to_back(60);
      test_receiver_backpressure(50);
      test_burst_drain(4, 10);
      drain_segments();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // run limit
   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
